/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent check macros; empty when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset
`define DQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked out of reset
`define DQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define DQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* sv/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg
// Codes, widths and the command type shared by the deque modules.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEF_CAPACITY = 32;
  localparam int CMD_DEPTH    = 2;

  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP       = 3'd4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ELEMENT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // control part of a queued command
  typedef struct packed {
    logic              wr_en;
    logic              dump;
    logic [STAT_W-1:0] status;
  } cmd_ctl_t;

endpackage

/* sv/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values in a ring buffer, with dump.
// ----------------------------------------------------------------------------
// Use:
//   Present an operation on in_operation / in_value with start high; the item
//   is taken on the rising edge where start is high and busy is low. Codes:
//   push back, push front, pop front, pop back, dump. Unused codes are taken
//   and give no result.
//   Results appear on out_kind / out_status / out_element / out_last with
//   out_valid high for exactly one cycle each. The receiver cannot stall, so
//   every result must be taken in the cycle it is shown.
// Timing:
//   A push or pop gives one status result via the command queue and result
//   register; the front part takes one such item every cycle while busy is low.
//   A dump of N elements streams N results on consecutive cycles, element
//   data taken straight from the RAM's registered read port; an empty dump
//   gives one result. While a dump sweeps the store the back part pops no
//   commands, so busy rises once the command queue fills.
// Reset:
//   Synchronous, active low. Head and fill level clear to zero and the
//   command queue empties; the element store keeps its contents, since only
//   written entries are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module double_ended_queue #(
  parameter int CAPACITY = dq_pkg::DEF_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [dq_pkg::OP_W-1:0]          in_operation,
  input  logic signed [dq_pkg::DATA_W-1:0] in_value,
  output logic                             out_valid,
  output logic [dq_pkg::KIND_W-1:0]        out_kind,
  output logic [dq_pkg::STAT_W-1:0]        out_status,
  output logic signed [dq_pkg::DATA_W-1:0] out_element,
  output logic                             out_last
);

  import dq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CTL_W = $bits(cmd_ctl_t);
  localparam int CMD_W = CTL_W + IDX_W + CNT_W + DATA_W;

  // front to command queue
  logic                     f_push;
  cmd_ctl_t                 f_ctl;
  logic [IDX_W-1:0]         f_addr;
  logic [CNT_W-1:0]         f_cnt;
  logic signed [DATA_W-1:0] f_data;
  logic [CNT_W-1:0]         level;

  // command queue to back
  logic [CMD_W-1:0]         q_wr_data;
  logic [CMD_W-1:0]         q_rd_data;
  logic                     q_full;
  logic                     q_not_empty;
  logic                     q_pop;
  cmd_ctl_t                 b_ctl;
  logic [IDX_W-1:0]         b_addr;
  logic [CNT_W-1:0]         b_cnt;
  logic signed [DATA_W-1:0] b_data;

  // back to store
  logic                     ram_wr_en;
  logic [IDX_W-1:0]         ram_wr_addr;
  logic [DATA_W-1:0]        ram_wr_data;
  logic                     ram_rd_en;
  logic [IDX_W-1:0]         ram_rd_addr;
  logic [DATA_W-1:0]        ram_rd_data;

  // Front: classify the item, advance head and level, queue a command
  dq_front #(
    .CAPACITY (CAPACITY)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .fifo_full (q_full),
    .operation (in_operation),
    .value     (in_value),
    .busy      (busy),
    .cmd_push  (f_push),
    .cmd_ctl   (f_ctl),
    .cmd_addr  (f_addr),
    .cmd_cnt   (f_cnt),
    .cmd_data  (f_data),
    .level     (level)
  );

  assign q_wr_data = {f_ctl, f_addr, f_cnt, f_data};

  // Hold commands so the front keeps taking items during a dump sweep
  dq_cmd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .wr_data   (q_wr_data),
    .pop       (q_pop),
    .rd_data   (q_rd_data),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  assign {b_ctl, b_addr, b_cnt, b_data} = q_rd_data;

  // Back: write the store, emit status, sweep the store for a dump
  dq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (q_not_empty),
    .cmd_ctl     (b_ctl),
    .cmd_addr    (b_addr),
    .cmd_cnt     (b_cnt),
    .cmd_data    (b_data),
    .cmd_pop     (q_pop),
    .wr_en       (ram_wr_en),
    .wr_addr     (ram_wr_addr),
    .wr_data     (ram_wr_data),
    .rd_en       (ram_rd_en),
    .rd_addr     (ram_rd_addr),
    .rd_data     (ram_rd_data),
    .out_valid   (out_valid),
    .out_kind    (out_kind),
    .out_status  (out_status),
    .out_element (out_element),
    .out_last    (out_last)
  );

  // Element store
  dq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Fill level never passes the capacity
  `DQ_ASSERT_IMP(a_level_bound, clk, rst_n, 1'b1, level <= CNT_W'(CAPACITY))
  // Status and empty-dump results always close their item
  `DQ_ASSERT_IMP(a_single_last, clk, rst_n, out_valid && out_kind != KIND_ELEMENT, out_last)
  // A dump streams without gaps until its last element
  `DQ_ASSERT_NXT(a_dump_stream, clk, rst_n, out_valid && out_kind == KIND_ELEMENT && !out_last, out_valid && out_kind == KIND_ELEMENT)

endmodule

/* sv/dq_ram.sv */
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/dq_front.sv */
// ----------------------------------------------------------------------------
// dq_front
// Accepts operations, tracks head and fill level, issues commands.
// ----------------------------------------------------------------------------
module dq_front #(
  parameter int CAPACITY = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             fifo_full,
  input  logic [dq_pkg::OP_W-1:0]          operation,
  input  logic signed [dq_pkg::DATA_W-1:0] value,
  output logic                             busy,
  output logic                             cmd_push,
  output dq_pkg::cmd_ctl_t                 cmd_ctl,
  output logic [$clog2(CAPACITY)-1:0]      cmd_addr,
  output logic [$clog2(CAPACITY+1)-1:0]    cmd_cnt,
  output logic signed [dq_pkg::DATA_W-1:0] cmd_data,
  output logic [$clog2(CAPACITY+1)-1:0]    level
);

  import dq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             accept;
  logic             full;
  logic             empty;
  logic [SUM_W-1:0] tail_sum;
  logic [IDX_W-1:0] tail_idx;
  logic [IDX_W-1:0] head_inc;
  logic [IDX_W-1:0] head_dec;

  assign busy   = fifo_full;
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign empty  = (count_r == '0);

  // slot past the back element, wrapped once
  assign tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail_idx = (tail_sum >= SUM_W'(CAPACITY)) ?
                    IDX_W'(tail_sum - SUM_W'(CAPACITY)) : IDX_W'(tail_sum);
  assign head_inc = (head_r == IDX_W'(CAPACITY - 1)) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? IDX_W'(CAPACITY - 1) : head_r - 1'b1;

  always_comb begin
    head_nxt       = head_r;
    count_nxt      = count_r;
    cmd_push       = 1'b0;
    cmd_ctl.wr_en  = 1'b0;
    cmd_ctl.dump   = 1'b0;
    cmd_ctl.status = ST_DONE;
    cmd_addr       = head_r;
    cmd_cnt        = count_r;
    cmd_data       = value;
    if (accept) begin
      unique case (operation)
        OP_PUSH_BACK: begin
          cmd_push = 1'b1;
          if (full) begin
            cmd_ctl.status = ST_FULL;
          end else begin
            cmd_ctl.wr_en = 1'b1;
            cmd_addr      = tail_idx;
            count_nxt     = count_r + 1'b1;
          end
        end
        OP_PUSH_FRONT: begin
          cmd_push = 1'b1;
          if (full) begin
            cmd_ctl.status = ST_FULL;
          end else begin
            cmd_ctl.wr_en = 1'b1;
            cmd_addr      = head_dec;
            head_nxt      = head_dec;
            count_nxt     = count_r + 1'b1;
          end
        end
        OP_POP_FRONT: begin
          cmd_push = 1'b1;
          if (empty) begin
            cmd_ctl.status = ST_EMPTY;
          end else begin
            head_nxt  = head_inc;
            count_nxt = count_r - 1'b1;
          end
        end
        OP_POP_BACK: begin
          cmd_push = 1'b1;
          if (empty) begin
            cmd_ctl.status = ST_EMPTY;
          end else begin
            count_nxt = count_r - 1'b1;
          end
        end
        OP_DUMP: begin
          cmd_push     = 1'b1;
          cmd_ctl.dump = 1'b1;
        end
        default: begin
          // unused codes: drop silently
          cmd_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  assign level = count_r;

endmodule

/* sv/dq_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// dq_cmd_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module dq_cmd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             not_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* sv/dq_back.sv */
// ----------------------------------------------------------------------------
// dq_back
// Executes queued commands: store writes, status results, dump sweeps.
// ----------------------------------------------------------------------------
module dq_back #(
  parameter int CAPACITY = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cmd_valid,
  input  dq_pkg::cmd_ctl_t                  cmd_ctl,
  input  logic [$clog2(CAPACITY)-1:0]       cmd_addr,
  input  logic [$clog2(CAPACITY+1)-1:0]     cmd_cnt,
  input  logic signed [dq_pkg::DATA_W-1:0]  cmd_data,
  output logic                              cmd_pop,
  output logic                              wr_en,
  output logic [$clog2(CAPACITY)-1:0]       wr_addr,
  output logic [dq_pkg::DATA_W-1:0]         wr_data,
  output logic                              rd_en,
  output logic [$clog2(CAPACITY)-1:0]       rd_addr,
  input  logic [dq_pkg::DATA_W-1:0]         rd_data,
  output logic                              out_valid,
  output logic [dq_pkg::KIND_W-1:0]         out_kind,
  output logic [dq_pkg::STAT_W-1:0]         out_status,
  output logic signed [dq_pkg::DATA_W-1:0]  out_element,
  output logic                              out_last
);

  import dq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic              state_r, state_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic              res_valid_r, res_valid_nxt;
  logic [KIND_W-1:0] res_kind_r, res_kind_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic              elem_valid_r, elem_valid_nxt;
  logic              elem_last_r, elem_last_nxt;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(CAPACITY - 1)) ? '0 : idx + 1'b1;
  endfunction

  assign wr_addr = cmd_addr;
  assign wr_data = cmd_data;

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    left_nxt       = left_r;
    res_valid_nxt  = 1'b0;
    res_kind_nxt   = KIND_STATUS;
    res_status_nxt = ST_DONE;
    elem_valid_nxt = 1'b0;
    elem_last_nxt  = 1'b0;
    cmd_pop        = 1'b0;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = ptr_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (!cmd_ctl.dump) begin
            wr_en          = cmd_ctl.wr_en;
            res_valid_nxt  = 1'b1;
            res_status_nxt = cmd_ctl.status;
          end else if (cmd_cnt == '0) begin
            res_valid_nxt = 1'b1;
            res_kind_nxt  = KIND_EMPTY;
          end else begin
            // first read of the sweep
            rd_en          = 1'b1;
            rd_addr        = cmd_addr;
            ptr_nxt        = wrap_inc(cmd_addr);
            left_nxt       = cmd_cnt - 1'b1;
            elem_valid_nxt = 1'b1;
            elem_last_nxt  = (cmd_cnt == CNT_W'(1));
            if (cmd_cnt != CNT_W'(1)) begin
              state_nxt = S_DUMP;
            end
          end
        end
      end
      S_DUMP: begin
        rd_en          = 1'b1;
        ptr_nxt        = wrap_inc(ptr_r);
        left_nxt       = left_r - 1'b1;
        elem_valid_nxt = 1'b1;
        elem_last_nxt  = (left_r == CNT_W'(1));
        if (left_r == CNT_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      res_valid_r  <= 1'b0;
      elem_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      res_valid_r  <= res_valid_nxt;
      elem_valid_r <= elem_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    left_r       <= left_nxt;
    res_kind_r   <= res_kind_nxt;
    res_status_r <= res_status_nxt;
    elem_last_r  <= elem_last_nxt;
  end

  // element results take the RAM read data as it comes out
  assign out_valid   = res_valid_r || elem_valid_r;
  assign out_kind    = elem_valid_r ? KIND_ELEMENT : res_kind_r;
  assign out_status  = elem_valid_r ? ST_DONE : res_status_r;
  assign out_element = elem_valid_r ? rd_data : '0;
  assign out_last    = elem_valid_r ? elem_last_r : res_valid_r;

endmodule

/* tb/double_ended_queue_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the ring-buffer deque: directed corner items, then
// bursts that fill, drain and mix the queue. A cycle-accurate-free model of
// the deque predicts every status and dump result; a monitor compares each
// strobed result in order against the oldest prediction.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
  import dq_pkg::*;

  localparam int CAPACITY      = DEF_CAPACITY;
  localparam int RANDOM_ITEMS  = 170;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int REPORT_MAX    = 10;

  // codes the block takes and ignores
  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

  // one command to send; hold_drain marks a pause until all results are in
  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    bit                       hold_drain;
  } dq_cmd_t;

  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] element;
    logic                     last;
  } dq_result_t;

  logic                     clk          = 1'b0;
  logic                     rst_n        = 1'b0;
  logic                     start        = 1'b0;
  logic [OP_W-1:0]          in_operation = OP_PUSH_BACK;
  logic signed [DATA_W-1:0] in_value     = '0;
  logic                     busy;
  logic                     out_valid;
  logic [KIND_W-1:0]        out_kind;
  logic [STAT_W-1:0]        out_status;
  logic signed [DATA_W-1:0] out_element;
  logic                     out_last;

  double_ended_queue #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_operation(in_operation),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_kind    (out_kind),
    .out_status  (out_status),
    .out_element (out_element),
    .out_last    (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Deque model: its own copy of the ring, front position and fill level
  // --------------------------------------------------------------------------
  logic signed [DATA_W-1:0] ring_slot [CAPACITY];
  int unsigned              front_pos  = 0;
  int unsigned              fill_level = 0;

  dq_cmd_t    cmd_q[$];       // items still to be sent
  dq_result_t due_results[$]; // results predicted but not yet seen
  int         results_due   = 0;  // owned by the driver
  int         results_taken = 0;  // owned by the monitor, updated at the edge
  int         sent_cnt      = 0;
  int         fault_cnt     = 0;
  int         cycle_cnt     = 0;

  task automatic note_result(input logic [KIND_W-1:0] kind,
                             input logic [STAT_W-1:0] status,
                             input logic signed [DATA_W-1:0] element,
                             input logic last);
    dq_result_t r;
    r.kind    = kind;
    r.status  = status;
    r.element = element;
    r.last    = last;
    due_results.push_back(r);
    results_due++;
  endtask

  // Advance the model by one taken item and queue the results it causes.
  task automatic deque_apply(input logic [OP_W-1:0] op,
                             input logic signed [DATA_W-1:0] val);
    logic [STAT_W-1:0] st;
    st = ST_DONE;
    case (op)
      OP_PUSH_BACK: begin
        if (fill_level >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          ring_slot[(front_pos + fill_level) % CAPACITY] = val;
          fill_level++;
        end
      end
      OP_PUSH_FRONT: begin
        if (fill_level >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          front_pos = (front_pos + CAPACITY - 1) % CAPACITY;
          ring_slot[front_pos] = val;
          fill_level++;
        end
      end
      OP_POP_FRONT: begin
        if (fill_level == 0) begin
          st = ST_EMPTY;
        end else begin
          front_pos = (front_pos + 1) % CAPACITY;
          fill_level--;
        end
      end
      OP_POP_BACK: begin
        if (fill_level == 0) st = ST_EMPTY;
        else fill_level--;
      end
      OP_DUMP: begin
        // walk head to tail; an empty queue still answers once
        if (fill_level == 0) begin
          note_result(KIND_EMPTY, ST_DONE, '0, 1'b1);
        end else begin
          for (int i = 0; i < fill_level; i++)
            note_result(KIND_ELEMENT, ST_DONE, ring_slot[(front_pos + i) % CAPACITY],
                        (i == fill_level - 1));
        end
        return;
      end
      default: return;  // unused code: nothing changes, nothing comes out
    endcase
    note_result(KIND_STATUS, st, '0, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_cmd(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val);
    dq_cmd_t c;
    c.op         = op;
    c.value      = val;
    c.hold_drain = 1'b0;
    cmd_q.push_back(c);
  endtask

  task automatic add_pause();
    dq_cmd_t c;
    c.op         = OP_PUSH_BACK;
    c.value      = '0;
    c.hold_drain = 1'b1;
    cmd_q.push_back(c);
  endtask

  // Mostly random values, with the extremes mixed in now and then
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $urandom_range(0, 1) ? 32'sh0 : -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_push();
    return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
  endfunction

  function automatic logic [OP_W-1:0] pick_pop();
    return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents items from cmd_q; holds an item while busy is high
  // --------------------------------------------------------------------------
  dq_cmd_t nxt_cmd;
  bit      idle_now;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        deque_apply(in_operation, in_value);
        sent_cnt++;
      end
      if (!(start && busy)) begin
        // release a pause once every predicted result has been seen
        while (cmd_q.size() != 0 && cmd_q[0].hold_drain && results_due == results_taken)
          void'(cmd_q.pop_front());
        // idle at random, except over a quiet stretch of back-to-back items
        idle_now = !(sent_cnt >= 80 && sent_cnt < 130) && ($urandom_range(0, 99) < 35);
        if (cmd_q.size() != 0 && !cmd_q[0].hold_drain && !idle_now) begin
          nxt_cmd = cmd_q.pop_front();
          start        <= 1'b1;
          in_operation <= nxt_cmd.op;
          in_value     <= nxt_cmd.value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every strobed result must match the oldest prediction
  // --------------------------------------------------------------------------
  dq_result_t want;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n && out_valid) begin
      results_taken <= results_taken + 1;
      if (due_results.size() == 0) begin
        if (fault_cnt < REPORT_MAX)
          $display("%0t: result with nothing due: kind %0d status %0d element %0d last %0d",
                   $time, out_kind, out_status, out_element, out_last);
        fault_cnt++;
      end else begin
        want = due_results.pop_front();
        if (out_kind !== want.kind || out_status !== want.status ||
            out_element !== want.element || out_last !== want.last) begin
          if (fault_cnt < REPORT_MAX)
            $display("%0t: exp/got kind %0d/%0d status %0d/%0d element %0d/%0d last %0d/%0d",
                     $time, want.kind, out_kind, want.status, out_status,
                     want.element, out_element, want.last, out_last);
          fault_cnt++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Build the item list, run, and judge
  // --------------------------------------------------------------------------
  initial begin
    int counted;
    int n;
    int burst;
    bit timed_out;
    logic [OP_W-1:0] op;

    // Directed: empty dump and pops on empty, pushes of the extreme values
    // from both ends, dumps, pops from both ends, the unused codes.
    add_cmd(OP_DUMP, pick_value());
    add_cmd(OP_POP_FRONT, 32'sh7FFF_FFFF);
    add_cmd(OP_POP_BACK, 32'sh8000_0000);
    add_cmd(OP_PUSH_BACK, 32'sh7FFF_FFFF);
    add_cmd(OP_PUSH_FRONT, 32'sh8000_0000);
    add_cmd(OP_PUSH_BACK, 32'sh0);
    add_cmd(OP_PUSH_FRONT, -32'sd1);
    add_cmd(OP_PUSH_BACK, 32'sh5555_5555);
    add_cmd(OP_PUSH_FRONT, 32'shAAAA_AAAA);
    add_cmd(OP_DUMP, 32'sh0);
    add_cmd(OP_POP_FRONT, 32'sh0);
    add_cmd(OP_POP_BACK, 32'sh0);
    add_cmd(OP_DUMP, -32'sd1);
    add_cmd(OP_UNUSED_FIRST, 32'sh1234_5678);
    add_cmd(OP_UNUSED_FIRST + 3'd1, -32'sd1);
    add_cmd(OP_UNUSED_LAST, 32'sh8000_0000);
    add_cmd(OP_DUMP, 32'sh0);
    add_pause();

    // directed items so far, less the pause
    counted = cmd_q.size() - 1;

    // First random bursts: fill past capacity (front/back pushes wrap the
    // head), dump a full queue, then drain past empty.
    for (int i = 0; i < CAPACITY + 4; i++) add_cmd(pick_push(), pick_value());
    add_cmd(OP_DUMP, pick_value());
    for (int i = 0; i < CAPACITY + 3; i++) add_cmd(pick_pop(), pick_value());
    add_cmd(OP_DUMP, pick_value());
    add_pause();
    counted += 2 * CAPACITY + 9;

    // Then mixed bursts until the item budget is spent
    while (counted < RANDOM_ITEMS) begin
      burst = $urandom_range(0, 2);
      n = (burst == 2) ? 12 : $urandom_range(6, CAPACITY + 6);
      // keep room for the closing dump
      if (n > RANDOM_ITEMS - counted - 1) n = RANDOM_ITEMS - counted - 1;
      for (int i = 0; i < n; i++) begin
        case (burst)
          0: op = ($urandom_range(0, 99) < 85) ? pick_push() : pick_pop();
          1: op = ($urandom_range(0, 99) < 85) ? pick_pop() : pick_push();
          default: begin
            if ($urandom_range(0, 99) < 5)
              op = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
            else
              op = OP_W'($urandom_range(OP_PUSH_BACK, OP_DUMP));
          end
        endcase
        add_cmd(op, pick_value());
        if (op <= OP_DUMP) counted++;
      end
      add_cmd(OP_DUMP, pick_value());
      counted++;
      if ($urandom_range(0, 3) == 0) add_pause();
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Sample at the falling edge so the driver and monitor have settled
    @(negedge clk);
    while ((cmd_q.size() != 0 || start || results_due != results_taken) &&
           cycle_cnt < CYCLE_LIMIT)
      @(negedge clk);
    timed_out = (cycle_cnt >= CYCLE_LIMIT);
    if (!timed_out) repeat (SETTLE_CYCLES) @(negedge clk);

    if (due_results.size() != 0)
      $display("%0d predicted results never arrived", due_results.size());

    if (timed_out) begin
      $display("** double_ended_queue: FAILED **");
    end else if (fault_cnt == 0 && due_results.size() == 0) begin
      $display("** double_ended_queue: PASSED **");
    end else begin
      $display("** double_ended_queue: FAILED **");
    end
    $finish;
  end

endmodule
